// ----- hw/rtl/bms_pkg.sv -----
// Shared constants and control/status types for the bounded membership set.
`default_nettype none

package bms_pkg;

    // Store geometry
    localparam int SLOTS   = 32;
    localparam int ID_BITS = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int CAP_W   = 6;
    localparam int FUNC_W  = 2;

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(SLOTS);

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture a new word and start a scan
        logic scan;    // one step of the search
        logic shift;   // one step of the compaction after a remove
        logic commit;  // update count, append on add, load the result register
    } bms_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;        // compared entry matches the requested id
        logic drained;    // no read outstanding and no entry left to read
        logic is_remove;  // captured request is a remove
        logic out_free;   // result register can take a new word
    } bms_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bms_ctrl.sv -----
// Sequencing state machine for the bounded membership set.
`default_nettype none

module bms_ctrl
    import bms_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  bms_stat_t      stat,
    output bms_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = stat.is_remove ? ST_SHIFT : ST_FIN;
                end
                else if (stat.drained)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.drained)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bms_dp.sv -----
// Datapath of the bounded membership set: member store, scan, compaction, result register.
`default_nettype none

module bms_dp
    import bms_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CAP_W-1:0]   cfg_wdata,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [ID_BITS-1:0] member_id,
    input  bms_cmd_t                cmd,
    output bms_stat_t               stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    ok,
    output logic [CNT_W-1:0]        count,
    output logic                    full_res
);

    logic [ID_BITS-1:0] mem [SLOTS];

    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic               found_reg;
    logic [ID_BITS-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic               ok_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               full_reg;

    logic [CNT_W-1:0]   eff_cap;
    logic               hit;
    logic               can_read;
    logic               add_ok;
    logic               rem_ok;
    logic               qry_ok;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic               rd_en;

    // Effective capacity is the smaller of the register and the store depth
    assign eff_cap = (CNT_W'(cap_reg) > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(cap_reg);

    assign hit      = pend_reg && (rd_data_reg == id_reg);
    assign can_read = ptr_reg < total_reg;

    assign stat.hit       = hit;
    assign stat.drained   = !pend_reg && !can_read;
    assign stat.is_remove = func_reg == FUNC_REMOVE;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Outcome of the request once the search is over
    assign add_ok = (func_reg == FUNC_ADD) && !found_reg && (total_reg < eff_cap);
    assign rem_ok = (func_reg == FUNC_REMOVE) && found_reg;
    assign qry_ok = (func_reg == FUNC_QUERY) && found_reg;

    always_comb
    begin
        total_next = total_reg;
        if (add_ok)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (rem_ok)
        begin
            total_next = total_reg - 1'b1;
        end
    end

    // Store port selection: compaction writes or the append on add
    assign rd_en   = (cmd.scan || cmd.shift) && can_read;
    assign wr_en   = (cmd.shift && pend_reg) || (cmd.commit && add_ok);
    assign wr_addr = cmd.shift ? pend_idx_reg : total_reg[IDX_W-1:0];
    assign wr_data = cmd.shift ? rd_data_reg : id_reg;

    // Member store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    // Capture the request word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            id_reg   <= member_id;
        end
    end

    // Pending read index: scan compares it, compaction writes to it
    always_ff @(posedge clk)
    begin
        if (cmd.scan && hit)
        begin
            pend_idx_reg <= pend_idx_reg;
        end
        else if (rd_en && cmd.scan)
        begin
            pend_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        else if (rd_en)
        begin
            pend_idx_reg <= IDX_W'(ptr_reg - 1'b1);
        end
    end

    // Walk the list: advance the read pointer, track the outstanding read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan && hit)
        begin
            // restart the pointer just past the match for compaction
            ptr_reg   <= CNT_W'(pend_idx_reg) + 1'b1;
            pend_reg  <= 1'b0;
            found_reg <= 1'b1;
        end
        else if (cmd.scan || cmd.shift)
        begin
            pend_reg <= rd_en;
            if (rd_en)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    // Member count and capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                total_reg <= total_next;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Result register: load on commit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            ok_reg    <= add_ok || rem_ok || qry_ok;
            count_reg <= total_next;
            full_reg  <= total_next >= eff_cap;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign count     = count_reg;
    assign full_res  = full_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_membership_set.sv -----
// Top level of the bounded membership set: controller plus datapath.
//
// Keeps up to min(capacity, 32) distinct 16-bit member ids in insertion order.
// Input channel (in_valid/in_ready) carries func (0 add, 1 remove, 2 query)
// and member_id; each word yields exactly one result word on the output
// channel (out_valid/out_ready) with ok, count and full_res.
// A word is taken only while the block is idle. It is then captured, the
// stored entries are searched (the search stops at the first match), on a
// successful remove the entries behind the match are compacted, and the
// count is updated and the result register loaded.
// The single read and single write port of the member store sets the pace:
// one entry read per cycle during both search and compaction.
// The result register separates the two channels; a stalled receiver only
// holds the next result in its final cycle until the register is taken.
// cfg_we writes capacity (reset value 32); the user must write it only while
// idle, which the block does not enforce. Reset clears the member count and
// channel state but not the store, as only entries below the count are read.
`default_nettype none

module bounded_membership_set
    import bms_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CAP_W-1:0]   cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [ID_BITS-1:0] member_id,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    ok,
    output logic [CNT_W-1:0]        count,
    output logic                    full_res
);

    bms_cmd_t  cmd;
    bms_stat_t stat;

    // Sequencer
    bms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store and result path
    bms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .func      (func),
        .member_id (member_id),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .count     (count),
        .full_res  (full_res)
    );

endmodule

`default_nettype wire
